// ----- sv/pcq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcq_pkg
// Shared types and codes of the paced command queue.
// ----------------------------------------------------------------------------
package pcq_pkg;

   localparam int WORD_W  = 16;
   localparam int TICK_W  = 24;
   localparam int LIST_W  = 64;
   localparam int OP_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [WORD_W-1:0] NO_PREFIX = 16'hBEEF;
   localparam logic [WORD_W-1:0] LIST_END  = 16'hFFFF;

   localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_START = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_STOP_CMD     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_PFX_STOP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_PFX   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_WORDS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SUFFIX_WORDS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INTER_TICKS  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STARTUP_TICKS = 3'd6;

   // affix settings seen by the enqueue sequencer
   typedef struct packed {
      logic [WORD_W-1:0] stop_cmd;
      logic              no_prefix_on_stop;
      logic [WORD_W-1:0] single_prefix;
      logic [LIST_W-1:0] prefix_words;
      logic [LIST_W-1:0] suffix_words;
   } pcq_cfg_type;

   // queue status seen by the control
   typedef struct packed {
      logic full;
      logic pending;
   } pcq_stat_type;

endpackage

// ----- sv/pcq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcq_if
// Request and response channels of the paced command queue.
// ----------------------------------------------------------------------------
interface pcq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] cmd;

   modport source (output valid, output op, output cmd, input ready);
   modport sink   (input valid, input op, input cmd, output ready);
endinterface

interface pcq_rsp_if;
   logic        valid;
   logic        ready;
   logic        sent_valid;
   logic [15:0] sent_cmd;
   logic        boot_done;
   logic        busy_res;
   logic        booting;
   logic        overflow;

   modport source (output valid, output sent_valid, output sent_cmd, output boot_done,
                   output busy_res, output booting, output overflow, input ready);
   modport sink   (input valid, input sent_valid, input sent_cmd, input boot_done,
                   input busy_res, input booting, input overflow, output ready);
endinterface

// ----- sv/pcq_affix_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcq_affix_seq
// Walks single prefix, packed prefixes, command and packed suffixes,
// offering at most one word per cycle to the queue store.
// ----------------------------------------------------------------------------
module pcq_affix_seq #(
   parameter int AFFIX_WORDS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [15:0]          start_cmd,
   input  pcq_pkg::pcq_cfg_type cfg,
   output logic                 push,
   output logic [15:0]          push_word,
   output logic                 done
);
   import pcq_pkg::*;

   localparam int KW = (AFFIX_WORDS > 1) ? $clog2(AFFIX_WORDS) : 1;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_SINGLE = 3'd1;
   localparam logic [2:0] PH_PRE    = 3'd2;
   localparam logic [2:0] PH_CMD    = 3'd3;
   localparam logic [2:0] PH_SUF    = 3'd4;

   logic [2:0]        phase_ff, phase_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [WORD_W-1:0] cmd_ff, cmd_in;
   logic [WORD_W-1:0] pre_w, suf_w;
   logic              last_k;

   assign pre_w  = cfg.prefix_words[WORD_W*k_ff +: WORD_W];
   assign suf_w  = cfg.suffix_words[WORD_W*k_ff +: WORD_W];
   assign last_k = (k_ff == KW'(AFFIX_WORDS - 1));

   always_comb begin
      phase_in  = phase_ff;
      k_in      = k_ff;
      cmd_in    = cmd_ff;
      push      = 1'b0;
      push_word = cmd_ff;
      done      = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               cmd_in = start_cmd;
               k_in   = '0;
               if (start_cmd == cfg.stop_cmd && cfg.no_prefix_on_stop) begin
                  phase_in = PH_CMD;
               end else begin
                  phase_in = PH_SINGLE;
               end
            end
         end
         PH_SINGLE: begin
            push      = (cfg.single_prefix != NO_PREFIX);
            push_word = cfg.single_prefix;
            k_in      = '0;
            phase_in  = PH_PRE;
         end
         PH_PRE: begin
            if (pre_w == LIST_END) begin
               phase_in = PH_CMD;
            end else begin
               push      = 1'b1;
               push_word = pre_w;
               if (last_k) begin
                  phase_in = PH_CMD;
               end else begin
                  k_in = k_ff + KW'(1);
               end
            end
         end
         PH_CMD: begin
            push      = 1'b1;
            push_word = cmd_ff;
            k_in      = '0;
            phase_in  = PH_SUF;
         end
         PH_SUF: begin
            if (suf_w == LIST_END) begin
               done     = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               push      = 1'b1;
               push_word = suf_w;
               if (last_k) begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  k_in = k_ff + KW'(1);
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      cmd_ff <= cmd_in;
   end

endmodule

// ----- sv/pcq_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcq_store
// Word memory with write and read pointers; both pointers fall back to
// zero once the last pending word is read.
// ----------------------------------------------------------------------------
module pcq_store #(
   parameter int QUEUE_DEPTH = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [15:0]           push_data,
   input  logic                  pop,
   output logic [15:0]           pop_data,
   output pcq_pkg::pcq_stat_type stat
);
   import pcq_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = $clog2(QUEUE_DEPTH);

   logic [WORD_W-1:0] mem [QUEUE_DEPTH];
   logic [WORD_W-1:0] rd_ff;
   logic [PW-1:0]     wi_ff, wi_in;
   logic [PW-1:0]     ri_ff, ri_in;
   logic [PW-1:0]     ri_next;
   logic              full;
   logic              do_write;

   assign full     = (wi_ff == PW'(QUEUE_DEPTH));
   assign do_write = push && !full;
   assign ri_next  = ri_ff + PW'(1);

   always_comb begin
      wi_in = wi_ff;
      ri_in = ri_ff;
      if (pop) begin
         if (ri_next == wi_ff) begin
            ri_in = '0;
            wi_in = '0;
         end else begin
            ri_in = ri_next;
         end
      end else if (do_write) begin
         wi_in = wi_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff <= '0;
         ri_ff <= '0;
      end else begin
         wi_ff <= wi_in;
         ri_ff <= ri_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wi_ff[AW-1:0]] <= push_data;
      end
      if (pop) begin
         rd_ff <= mem[ri_ff[AW-1:0]];
      end
   end

   assign pop_data     = rd_ff;
   assign stat.full    = full;
   assign stat.pending = (ri_ff != wi_ff);

endmodule

// ----- sv/paced_command_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paced_command_queue
// Command queue with prefix/suffix expansion and tick-paced dispatch.
// ----------------------------------------------------------------------------
// One request is handled at a time and every request gives one response.
// An enqueue runs the affix sequencer, which writes at most one word per
// cycle through the single memory write port; for the stop command the
// prefixes can be skipped. A tick that sends a word passes through a read
// state for the registered memory read before its response; any other
// tick, a start and an unknown op are answered straight from idle. A new
// request is taken on the edge after the previous response has been taken.
// The memory needs no clearing pass after reset.
module paced_command_queue #(
   parameter int QUEUE_DEPTH = 512,
   parameter int AFFIX_WORDS = 4
) (
   input  logic        clock,
   input  logic        reset,
   pcq_req_if.sink     req_chan,
   pcq_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import pcq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ENQ  = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   // configuration
   logic [WORD_W-1:0] stop_cmd_ff;
   logic              no_pfx_stop_ff;
   logic [WORD_W-1:0] single_pfx_ff;
   logic [LIST_W-1:0] prefix_words_ff;
   logic [LIST_W-1:0] suffix_words_ff;
   logic [TICK_W-1:0] inter_ticks_ff;
   logic [TICK_W-1:0] startup_ticks_ff;

   // control
   logic [1:0]        state_ff, state_in;
   logic              busy_ff, busy_in;
   logic              boot_ff, boot_in;
   logic [TICK_W-1:0] rem_ff, rem_in;
   logic              ovf_ff, ovf_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_sent_ff, rsp_sent_in;
   logic [WORD_W-1:0] rsp_cmd_ff, rsp_cmd_in;
   logic              rsp_boot_done_ff, rsp_boot_done_in;
   logic              rsp_busy_ff, rsp_busy_in;
   logic              rsp_booting_ff, rsp_booting_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic              accept;
   logic              seq_start;
   logic              seq_push;
   logic [WORD_W-1:0] seq_word;
   logic              seq_done;
   logic              st_push;
   logic              st_pop;
   logic [WORD_W-1:0] st_data;
   pcq_stat_type      st_stat;
   pcq_cfg_type       cfg;
   logic [TICK_W-1:0] rem_dec;
   logic [TICK_W-1:0] inter_ivl;
   logic [TICK_W-1:0] boot_ivl;

   assign cfg.stop_cmd          = stop_cmd_ff;
   assign cfg.no_prefix_on_stop = no_pfx_stop_ff;
   assign cfg.single_prefix     = single_pfx_ff;
   assign cfg.prefix_words      = prefix_words_ff;
   assign cfg.suffix_words      = suffix_words_ff;

   assign req_chan.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;

   // a zero interval behaves as one tick
   assign inter_ivl = (inter_ticks_ff == '0) ? TICK_W'(1) : inter_ticks_ff;
   assign boot_ivl  = (startup_ticks_ff == '0) ? TICK_W'(1) : startup_ticks_ff;
   assign rem_dec   = (rem_ff == '0) ? '0 : rem_ff - TICK_W'(1);

   pcq_affix_seq #(
      .AFFIX_WORDS (AFFIX_WORDS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (seq_start),
      .start_cmd (req_chan.cmd),
      .cfg       (cfg),
      .push      (seq_push),
      .push_word (seq_word),
      .done      (seq_done)
   );

   pcq_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .push      (st_push),
      .push_data (seq_word),
      .pop       (st_pop),
      .pop_data  (st_data),
      .stat      (st_stat)
   );

   always_comb begin
      state_in         = state_ff;
      busy_in          = busy_ff;
      boot_in          = boot_ff;
      rem_in           = rem_ff;
      ovf_in           = ovf_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_sent_in      = rsp_sent_ff;
      rsp_cmd_in       = rsp_cmd_ff;
      rsp_boot_done_in = rsp_boot_done_ff;
      rsp_busy_in      = rsp_busy_ff;
      rsp_booting_in   = rsp_booting_ff;
      rsp_ovf_in       = rsp_ovf_ff;
      seq_start        = 1'b0;
      st_push          = 1'b0;
      st_pop           = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_boot_done_in = 1'b0;
               case (req_chan.op)
                  OP_ENQ: begin
                     seq_start = 1'b1;
                     ovf_in    = 1'b0;
                     state_in  = ST_ENQ;
                  end
                  OP_TICK: begin
                     if (busy_ff) begin
                        rem_in = rem_dec;
                        if (rem_dec == '0) begin
                           busy_in = 1'b0;
                           if (boot_ff) begin
                              boot_in          = 1'b0;
                              rsp_boot_done_in = 1'b1;
                           end else if (st_stat.pending) begin
                              st_pop   = 1'b1;
                              state_in = ST_READ;
                           end
                        end
                     end else if (st_stat.pending) begin
                        busy_in = 1'b1;
                        rem_in  = inter_ivl;
                     end
                  end
                  OP_START: begin
                     busy_in = 1'b1;
                     boot_in = 1'b1;
                     rem_in  = boot_ivl;
                  end
                  default: begin
                  end
               endcase
               if (req_chan.op != OP_ENQ && !st_pop) begin
                  rsp_valid_in   = 1'b1;
                  rsp_sent_in    = 1'b0;
                  rsp_cmd_in     = '0;
                  rsp_busy_in    = busy_in;
                  rsp_booting_in = boot_in;
                  rsp_ovf_in     = 1'b0;
               end
            end
         end
         ST_ENQ: begin
            st_push = seq_push && !st_stat.full;
            if (seq_push && st_stat.full) begin
               ovf_in = 1'b1;
            end
            if (seq_done) begin
               rsp_valid_in     = 1'b1;
               rsp_sent_in      = 1'b0;
               rsp_cmd_in       = '0;
               rsp_boot_done_in = 1'b0;
               rsp_busy_in      = busy_ff;
               rsp_booting_in   = boot_ff;
               rsp_ovf_in       = ovf_in;
               state_in         = ST_IDLE;
            end
         end
         ST_READ: begin
            // memory data registered on the previous edge
            rsp_valid_in     = 1'b1;
            rsp_sent_in      = 1'b1;
            rsp_cmd_in       = st_data;
            rsp_boot_done_in = 1'b0;
            rsp_busy_in      = busy_ff;
            rsp_booting_in   = boot_ff;
            rsp_ovf_in       = 1'b0;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         boot_ff      <= 1'b0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         boot_ff      <= boot_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff           <= ovf_in;
      rsp_sent_ff      <= rsp_sent_in;
      rsp_cmd_ff       <= rsp_cmd_in;
      rsp_boot_done_ff <= rsp_boot_done_in;
      rsp_busy_ff      <= rsp_busy_in;
      rsp_booting_ff   <= rsp_booting_in;
      rsp_ovf_ff       <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_cmd_ff      <= '0;
         no_pfx_stop_ff   <= 1'b0;
         single_pfx_ff    <= NO_PREFIX;
         prefix_words_ff  <= '1;
         suffix_words_ff  <= '1;
         inter_ticks_ff   <= TICK_W'(1);
         startup_ticks_ff <= TICK_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_STOP_CMD:      stop_cmd_ff      <= csr_wdata[WORD_W-1:0];
            CSR_NO_PFX_STOP:   no_pfx_stop_ff   <= csr_wdata[0];
            CSR_SINGLE_PFX:    single_pfx_ff    <= csr_wdata[WORD_W-1:0];
            CSR_PREFIX_WORDS:  prefix_words_ff  <= csr_wdata[LIST_W-1:0];
            CSR_SUFFIX_WORDS:  suffix_words_ff  <= csr_wdata[LIST_W-1:0];
            CSR_INTER_TICKS:   inter_ticks_ff   <= csr_wdata[TICK_W-1:0];
            CSR_STARTUP_TICKS: startup_ticks_ff <= csr_wdata[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sent_valid = rsp_sent_ff;
   assign rsp_chan.sent_cmd   = rsp_cmd_ff;
   assign rsp_chan.boot_done  = rsp_boot_done_ff;
   assign rsp_chan.busy_res   = rsp_busy_ff;
   assign rsp_chan.booting    = rsp_booting_ff;
   assign rsp_chan.overflow   = rsp_ovf_ff;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the paced command queue: a directed script, then
// random phases, each reply checked against a scripted reply or a cycle-free model.
// ----------------------------------------------------------------------------
module tb;
   import pcq_pkg::*;

   localparam int QUEUE_DEPTH = 512;
   localparam int AFFIX_WORDS = 4;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_GOAL = 1550;

   typedef struct packed {
      logic              sent_valid;
      logic [WORD_W-1:0] sent_cmd;
      logic              boot_done;
      logic              busy_res;
      logic              booting;
      logic              overflow;
   } reply_type;

   typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [OP_W-1:0]   op;
      logic [WORD_W-1:0] cmd;
      logic [2:0]        reg_idx;
      logic [63:0]       reg_val;
      logic              typed;
      reply_type         want;
   } plan_row_type;

   typedef enum {PH_MIXED, PH_FLOOD, PH_SLOW_DISPATCH, PH_SLOW_BOOT} phase_type;

   localparam reply_type REPLY_QUIET     = '0;
   localparam reply_type REPLY_ARMED     = '{busy_res: 1'b1, default: '0};
   localparam reply_type REPLY_BOOTING   = '{busy_res: 1'b1, booting: 1'b1, default: '0};
   localparam reply_type REPLY_BOOT_DONE = '{boot_done: 1'b1, default: '0};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   pcq_req_if req_chan();
   pcq_rsp_if rsp_chan();

   paced_command_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .AFFIX_WORDS(AFFIX_WORDS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // queue model state
   logic [WORD_W-1:0] word_mem [QUEUE_DEPTH];
   int                fill_ptr;
   int                drain_ptr;
   bit                pacing;
   bit                in_boot;
   int                ticks_left;

   // register shadows
   logic [WORD_W-1:0] stop_word;
   logic              skip_pfx_on_stop;
   logic [WORD_W-1:0] lone_prefix;
   logic [LIST_W-1:0] prefix_list;
   logic [LIST_W-1:0] suffix_list;
   logic [TICK_W-1:0] gap_ticks;
   logic [TICK_W-1:0] boot_ticks;

   reply_type expected_replies [$];
   int        mismatches;
   int        requests_sent;
   int        req_idle_max;
   int        rsp_idle_max;

   plan_row_type script [27] = '{
      '{ROW_REQUEST, OP_TICK,   16'h0000, '0, '0, 1'b1, REPLY_QUIET},
      '{ROW_REQUEST, OP_UNUSED, 16'hA5A5, '0, '0, 1'b1, REPLY_QUIET},
      '{ROW_REQUEST, OP_ENQ,    16'h0000, '0, '0, 1'b1, REPLY_QUIET},
      '{ROW_REQUEST, OP_ENQ,    16'hFFFF, '0, '0, 1'b1, REPLY_QUIET},
      '{ROW_REQUEST, OP_TICK,   16'h0000, '0, '0, 1'b1, REPLY_ARMED},
      '{ROW_REQUEST, OP_TICK,   16'h0000, '0, '0, 1'b1,
        '{sent_valid: 1'b1, sent_cmd: 16'h0000, default: '0}},
      '{ROW_REQUEST, OP_TICK,   16'hFFFF, '0, '0, 1'b1, REPLY_ARMED},
      '{ROW_REQUEST, OP_TICK,   16'h0000, '0, '0, 1'b1,
        '{sent_valid: 1'b1, sent_cmd: 16'hFFFF, default: '0}},
      '{ROW_REQUEST, OP_START,  16'h0000, '0, '0, 1'b1, REPLY_BOOTING},
      '{ROW_REQUEST, OP_ENQ,    16'h1234, '0, '0, 1'b1, REPLY_BOOTING},
      '{ROW_REQUEST, OP_TICK,   16'h0000, '0, '0, 1'b1, REPLY_BOOT_DONE},
      '{ROW_REQUEST, OP_TICK,   16'h0000, '0, '0, 1'b1, REPLY_ARMED},
      // start while a dispatch is counting down
      '{ROW_REQUEST, OP_START,  16'h0000, '0, '0, 1'b1, REPLY_BOOTING},
      '{ROW_REQUEST, OP_TICK,   16'h0000, '0, '0, 1'b1, REPLY_BOOT_DONE},
      '{ROW_REQUEST, OP_TICK,   16'h0000, '0, '0, 1'b1, REPLY_ARMED},
      '{ROW_REQUEST, OP_TICK,   16'h0000, '0, '0, 1'b1,
        '{sent_valid: 1'b1, sent_cmd: 16'h1234, default: '0}},
      '{ROW_WRITE, '0, '0, CSR_SINGLE_PFX,   64'h0000_0000_0000_0001, 1'b0, '0},
      '{ROW_WRITE, '0, '0, CSR_PREFIX_WORDS, 64'hFFFF_0000_0003_0002, 1'b0, '0},
      '{ROW_WRITE, '0, '0, CSR_SUFFIX_WORDS, 64'h0000_FFFF_8000_7FFF, 1'b0, '0},
      '{ROW_WRITE, '0, '0, CSR_STOP_CMD,     64'h0000_0000_0000_FFFE, 1'b0, '0},
      '{ROW_WRITE, '0, '0, CSR_NO_PFX_STOP,  64'h0000_0000_0000_0001, 1'b0, '0},
      '{ROW_REQUEST, OP_ENQ,    16'hFFFE, '0, '0, 1'b0, '0},
      '{ROW_REQUEST, OP_ENQ,    16'h0042, '0, '0, 1'b0, '0},
      '{ROW_REQUEST, OP_TICK,   16'h0000, '0, '0, 1'b0, '0},
      '{ROW_REQUEST, OP_TICK,   16'h0000, '0, '0, 1'b0, '0},
      '{ROW_WRITE, '0, '0, CSR_NO_PFX_STOP,  64'h0000_0000_0000_0000, 1'b0, '0},
      '{ROW_REQUEST, OP_ENQ,    16'hFFFE, '0, '0, 1'b0, '0}
   };

   function automatic bit append_word(input logic [WORD_W-1:0] w);
      if (fill_ptr >= QUEUE_DEPTH)
         return 1'b0;
      word_mem[fill_ptr] = w;
      fill_ptr++;
      return 1'b1;
   endfunction

   // packed list stops at the first end marker; words past a full queue are lost
   function automatic bit append_list(input logic [LIST_W-1:0] list);
      bit ok;
      logic [WORD_W-1:0] w;
      ok = 1'b1;
      for (int k = 0; k < AFFIX_WORDS; k++) begin
         w = list[WORD_W*k +: WORD_W];
         if (w == LIST_END)
            break;
         if (!append_word(w))
            ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic reply_type advance_queue(input logic [OP_W-1:0] op,
                                               input logic [WORD_W-1:0] cmd);
      reply_type r;
      bit fits;
      r = '0;
      fits = 1'b1;
      case (op)
         OP_ENQ: begin
            if (cmd != stop_word || !skip_pfx_on_stop) begin
               if (lone_prefix != NO_PREFIX)
                  fits &= append_word(lone_prefix);
               fits &= append_list(prefix_list);
            end
            fits &= append_word(cmd);
            fits &= append_list(suffix_list);
            r.overflow = !fits;
         end
         OP_TICK: begin
            if (pacing) begin
               if (ticks_left > 0)
                  ticks_left--;
               if (ticks_left == 0) begin
                  pacing = 1'b0;
                  if (in_boot) begin
                     in_boot = 1'b0;
                     r.boot_done = 1'b1;
                  end else if (drain_ptr < fill_ptr) begin
                     r.sent_valid = 1'b1;
                     r.sent_cmd = word_mem[drain_ptr];
                     drain_ptr++;
                     if (drain_ptr == fill_ptr) begin
                        drain_ptr = 0;
                        fill_ptr = 0;
                     end
                  end
               end
            end else if (drain_ptr != fill_ptr) begin
               // arming tick itself does not count
               pacing = 1'b1;
               ticks_left = (gap_ticks == 0) ? 1 : int'(gap_ticks);
            end
         end
         OP_START: begin
            pacing = 1'b1;
            in_boot = 1'b1;
            ticks_left = (boot_ticks == 0) ? 1 : int'(boot_ticks);
         end
         default: ;
      endcase
      r.busy_res = pacing;
      r.booting = in_boot;
      return r;
   endfunction

   function automatic logic [LIST_W-1:0] build_list(input bit full);
      logic [LIST_W-1:0] v;
      int len;
      v = '0;
      len = full ? AFFIX_WORDS : $urandom_range(0, 6);
      if (len == 5)
         return {$urandom, $urandom};
      if (len == 6)
         return '0;
      for (int k = 0; k < 4; k++) begin
         if (k < len)
            v[WORD_W*k +: WORD_W] = WORD_W'($urandom_range(0, 16'hFFFE));
         else if (k == len)
            v[WORD_W*k +: WORD_W] = LIST_END;
         else
            v[WORD_W*k +: WORD_W] = WORD_W'($urandom_range(0, 16'hFFFF));
      end
      return v;
   endfunction

   // a quarter of commands hit the stop command
   function automatic logic [WORD_W-1:0] draw_cmd();
      if ($urandom_range(0, 3) == 0)
         return stop_word;
      return WORD_W'($urandom_range(0, 16'hFFFF));
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic push_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] cmd,
                               input bit typed = 1'b0, input reply_type want = '0);
      int gap;
      reply_type predicted;
      gap = $urandom_range(0, req_idle_max);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.cmd <= cmd;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted = advance_queue(op, cmd);
      expected_replies.push_back(typed ? want : predicted);
      requests_sent++;
   endtask

   // drop valid and wait for every outstanding request to be answered
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_replies.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_STOP_CMD:      stop_word = val[WORD_W-1:0];
         CSR_NO_PFX_STOP:   skip_pfx_on_stop = val[0];
         CSR_SINGLE_PFX:    lone_prefix = val[WORD_W-1:0];
         CSR_PREFIX_WORDS:  prefix_list = val;
         CSR_SUFFIX_WORDS:  suffix_list = val;
         CSR_INTER_TICKS:   gap_ticks = val[TICK_W-1:0];
         CSR_STARTUP_TICKS: boot_ticks = val[TICK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic run_phase(input phase_type kind);
      int n;
      int first;
      int g;
      int cap;
      logic [WORD_W-1:0] stop_v;
      logic [WORD_W-1:0] single_v;
      logic [TICK_W-1:0] gap_v;
      logic [TICK_W-1:0] boot_v;
      bit skip_v;
      settle();
      req_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
      rsp_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
      case ($urandom_range(0, 3))
         0: stop_v = 16'h0000;
         1: stop_v = 16'hFFFE;
         2: stop_v = 16'hFFFF;
         default: stop_v = WORD_W'($urandom_range(0, 16'hFFFF));
      endcase
      skip_v = 1'($urandom_range(0, 1));
      single_v = $urandom_range(0, 1) ? NO_PREFIX : WORD_W'($urandom_range(0, 16'hFFFF));
      gap_v = TICK_W'($urandom_range(0, 3));
      boot_v = TICK_W'($urandom_range(0, 3));
      if (kind == PH_FLOOD) begin
         // ten words per request fills the queue in a few dozen requests
         skip_v = 1'b0;
         single_v = WORD_W'($urandom_range(0, 16'hBEEE));
         gap_v = TICK_W'($urandom_range(0, 1));
      end else if (kind == PH_SLOW_DISPATCH) begin
         gap_v = '1;
         boot_v = '0;
      end else if (kind == PH_SLOW_BOOT) begin
         gap_v = '0;
         boot_v = '1;
      end
      write_register(CSR_STOP_CMD, 64'(stop_v));
      write_register(CSR_NO_PFX_STOP, 64'(skip_v));
      write_register(CSR_SINGLE_PFX, 64'(single_v));
      write_register(CSR_PREFIX_WORDS, build_list(kind == PH_FLOOD));
      write_register(CSR_SUFFIX_WORDS, build_list(kind == PH_FLOOD));
      write_register(CSR_INTER_TICKS, 64'(gap_v));
      write_register(CSR_STARTUP_TICKS, 64'(boot_v));
      // a start clears any long countdown left by the previous phase
      push_request(OP_START, draw_cmd());
      case (kind)
         PH_FLOOD: begin
            repeat (56) push_request(OP_ENQ, draw_cmd());
            while (fill_ptr != 0)
               push_request(OP_TICK, draw_cmd());
         end
         PH_SLOW_DISPATCH, PH_SLOW_BOOT: begin
            repeat (20)
               push_request($urandom_range(0, 1) ? OP_ENQ : OP_TICK, draw_cmd());
         end
         default: begin
            n = $urandom_range(40, 90);
            first = requests_sent;
            while (requests_sent - first < n) begin
               g = $urandom_range(0, 9);
               if (g == 0) begin
                  push_request(OP_W'($urandom_range(0, 3)), draw_cmd());
               end else if (g == 1) begin
                  push_request(OP_START, draw_cmd());
               end else begin
                  repeat ($urandom_range(1, 3)) push_request(OP_ENQ, draw_cmd());
                  cap = 80;
                  while (fill_ptr != 0 && cap > 0) begin
                     push_request(OP_TICK, draw_cmd());
                     cap--;
                  end
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      reply_type seen;
      reply_type due;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         seen = '{sent_valid: rsp_chan.sent_valid, sent_cmd: rsp_chan.sent_cmd,
                  boot_done: rsp_chan.boot_done, busy_res: rsp_chan.busy_res,
                  booting: rsp_chan.booting, overflow: rsp_chan.overflow};
         if (expected_replies.size() == 0) begin
            $display("%0t: response with nothing outstanding, expected none got %p",
                     $time, seen);
            mismatches++;
         end else begin
            due = expected_replies.pop_front();
            compare_field("sent_valid", 16'(due.sent_valid), 16'(seen.sent_valid));
            compare_field("sent_cmd", due.sent_cmd, seen.sent_cmd);
            compare_field("boot_done", 16'(due.boot_done), 16'(seen.boot_done));
            compare_field("busy_res", 16'(due.busy_res), 16'(seen.busy_res));
            compare_field("booting", 16'(due.booting), 16'(seen.booting));
            compare_field("overflow", 16'(due.overflow), 16'(seen.overflow));
         end
      end
   end

   // response side back-pressure
   initial begin
      int stall;
      wait (reset === 1'b0);
      forever begin
         stall = $urandom_range(0, rsp_idle_max);
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.op = OP_ENQ;
      req_chan.cmd = '0;
      rsp_chan.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_STOP_CMD;
      csr_wdata = '0;
      fill_ptr = 0;
      drain_ptr = 0;
      pacing = 1'b0;
      in_boot = 1'b0;
      ticks_left = 0;
      stop_word = '0;
      skip_pfx_on_stop = 1'b0;
      lone_prefix = NO_PREFIX;
      prefix_list = '1;
      suffix_list = '1;
      gap_ticks = TICK_W'(1);
      boot_ticks = TICK_W'(1);
      mismatches = 0;
      requests_sent = 0;
      req_idle_max = 14;
      rsp_idle_max = 14;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_WRITE) begin
            settle();
            write_register(script[i].reg_idx, script[i].reg_val);
         end else begin
            push_request(script[i].op, script[i].cmd, script[i].typed, script[i].want);
         end
      end

      run_phase(PH_MIXED);
      run_phase(PH_FLOOD);
      run_phase(PH_SLOW_DISPATCH);
      run_phase(PH_MIXED);
      run_phase(PH_SLOW_BOOT);
      while (requests_sent < ITEM_GOAL)
         run_phase(PH_MIXED);

      settle();
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
